[hw/rtl/gamepad_poll_sequencer_macros.svh]
// Assertion macros shared by the pad poll sequencer.
`ifndef GAMEPAD_POLL_SEQUENCER_MACROS_SVH
`define GAMEPAD_POLL_SEQUENCER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GPS_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GPS_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/gps_pkg.sv]
// Types, constants and codes of the pad poll sequencer.
`default_nettype none
package gps_pkg;

	localparam int REPLY_BYTES  = 21;
	localparam int ANALOG_BYTES = 16;
	localparam int ANALOG_SLOTS = 16;
	localparam int POS_W        = $clog2(REPLY_BYTES + 1);
	localparam int IDX_W        = $clog2(REPLY_BYTES);
	localparam int VIEW_N       = 5 + ANALOG_SLOTS;
	localparam int TIME_W       = 48;
	localparam int DELAY_W      = 24;
	localparam int WINDOW_W     = 32;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_IDX_W    = 3;

	localparam logic [POS_W-1:0] REPLY_CNT = POS_W'(REPLY_BYTES);

	localparam logic [7:0] HDR_BYTE     = 8'hFF;
	localparam logic [7:0] HDR_Z        = 8'h5A;
	localparam logic [7:0] MODE_DIGITAL = 8'h41;
	localparam logic [7:0] ALIGN_MIN    = 8'd2;

	localparam logic [4:0] LEN_SHORT = 5'd5;
	localparam logic [4:0] LEN_CFG   = 5'd9;
	localparam logic [4:0] LEN_FULL  = 5'(REPLY_BYTES);

	localparam logic [DELAY_W-1:0]  DISCOVERY_RST = 24'd500000;
	localparam logic [DELAY_W-1:0]  QUERY_RST     = 24'd100000;
	localparam logic [DELAY_W-1:0]  ACTIVE_RST    = 24'd5000;
	localparam logic [DELAY_W-1:0]  PASSIVE_RST   = 24'd100000;
	localparam logic [WINDOW_W-1:0] IDLE_RST      = 32'd180000000;

	typedef enum logic [2:0] {
		CMD_ENTER = 3'd0,
		CMD_QUERY = 3'd1,
		CMD_ALIGN = 3'd2,
		CMD_EXIT  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISCOVERY    = 3'd0,
		REG_QUERY        = 3'd1,
		REG_ACTIVE       = 3'd2,
		REG_PASSIVE      = 3'd3,
		REG_IDLE         = 3'd4,
		REG_RUMBLE_SMALL = 3'd5,
		REG_RUMBLE_LARGE = 3'd6
	} reg_t;

	typedef struct packed {
		logic [DELAY_W-1:0]  discovery_us;
		logic [DELAY_W-1:0]  query_us;
		logic [DELAY_W-1:0]  active_us;
		logic [DELAY_W-1:0]  passive_us;
		logic [WINDOW_W-1:0] idle_us;
	} cfg_t;

	// A completed reply waiting for decode.
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] now;
		logic [POS_W-1:0]  count;
	} reply_t;

endpackage
`default_nettype wire

[hw/rtl/gps_ifs.sv]
// Channel interfaces of the pad poll sequencer.
`default_nettype none
interface gps_req_if;
	import gps_pkg::*;
	logic              valid;
	logic              ready;
	logic [7:0]        rx_byte;
	logic              last_byte;
	logic [TIME_W-1:0] now_us;
	modport source (output valid, rx_byte, last_byte, now_us, input ready);
	modport sink (input valid, rx_byte, last_byte, now_us, output ready);
endinterface

interface gps_rsp_if;
	import gps_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        next_command;
	logic [TIME_W-1:0] next_due_us;
	logic [4:0]        reply_length;
	logic              report;
	logic [7:0]        device_mode;
	logic [7:0]        model_type;
	logic [7:0]        model_modes;
	logic [7:0]        model_mode;
	logic [7:0]        model_actuators;
	logic [15:0]       buttons;
	logic [63:0]       analog_low;
	logic [63:0]       analog_high;
	modport source (output valid, next_command, next_due_us, reply_length, report,
		device_mode, model_type, model_modes, model_mode, model_actuators, buttons,
		analog_low, analog_high, input ready);
	modport sink (input valid, next_command, next_due_us, reply_length, report,
		device_mode, model_type, model_modes, model_mode, model_actuators, buttons,
		analog_low, analog_high, output ready);
endinterface

interface gps_cfg_if;
	import gps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/gamepad_poll_sequencer.sv]
// Top level of the pad poll sequencer.
//
//   channel | direction | transaction
//   req     | in        | one reply byte with last flag and time stamp
//   rsp     | out       | next command, due time, reply length and pad state
//   cfg     | in        | one register write (index, data)
//
// One reply byte is accepted every cycle, but for the stall named below. The byte
// flagged last enters the decode stage; its result is registered, decoded in a
// single pass from the reply register file. Reset clears the control and pad
// state at once; no clearing pass follows. While a decoded reply waits because
// the result register holds an untaken result, no byte of any kind is accepted.
`default_nettype none
module gamepad_poll_sequencer (
	input  wire logic clk,
	input  wire logic arst_n,
	gps_req_if.sink   req,
	gps_rsp_if.source rsp,
	gps_cfg_if.sink   cfg
);
	import gps_pkg::*;
	`include "gamepad_poll_sequencer_macros.svh"

	cfg_t                         regs;
	reply_t                       reply;
	logic [REPLY_BYTES-1:0][7:0]  store;
	logic                         advance;

	gps_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	gps_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.advance (advance),
		.reply   (reply),
		.store   (store)
	);

	gps_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs),
		.reply   (reply),
		.store   (store),
		.advance (advance),
		.rsp     (rsp)
	);

	`GPS_ASSERT_NEXT(a_last_enters_decode, clk, arst_n, req.valid && req.ready && req.last_byte, reply.valid, "accepted last byte did not reach decode")
	`GPS_ASSERT_NOW(a_enter_len, clk, arst_n, rsp.valid && rsp.next_command == CMD_ENTER, rsp.reply_length == LEN_SHORT, "enter config must expect a short reply")
	`GPS_ASSERT_NOW(a_cfg_len, clk, arst_n, rsp.valid && rsp.next_command != CMD_ENTER && rsp.next_command != CMD_READ, rsp.reply_length == LEN_CFG, "configuration step must expect nine bytes")

endmodule
`default_nettype wire

[hw/rtl/gps_regs.sv]
// Configuration registers of the pad poll sequencer.
`default_nettype none
module gps_regs (
	input  wire logic      clk,
	input  wire logic      arst_n,
	gps_cfg_if.sink        cfg,
	output gps_pkg::cfg_t  regs
);
	import gps_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.discovery_us <= DISCOVERY_RST;
			regs_q.query_us     <= QUERY_RST;
			regs_q.active_us    <= ACTIVE_RST;
			regs_q.passive_us   <= PASSIVE_RST;
			regs_q.idle_us      <= IDLE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DISCOVERY: regs_q.discovery_us <= cfg.data[DELAY_W-1:0];
				REG_QUERY:     regs_q.query_us     <= cfg.data[DELAY_W-1:0];
				REG_ACTIVE:    regs_q.active_us    <= cfg.data[DELAY_W-1:0];
				REG_PASSIVE:   regs_q.passive_us   <= cfg.data[DELAY_W-1:0];
				REG_IDLE:      regs_q.idle_us      <= cfg.data[WINDOW_W-1:0];
				// The motor bytes are not stored; writes to them are accepted and dropped.
				REG_RUMBLE_SMALL: ;
				REG_RUMBLE_LARGE: ;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/gps_capture.sv]
// Reply byte capture: position counter, reply register file and decode stage entry.
`default_nettype none
module gps_capture (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	gps_req_if.sink                                    req,
	input  wire logic                                  advance,
	output gps_pkg::reply_t                            reply,
	output logic [gps_pkg::REPLY_BYTES-1:0][7:0]       store
);
	import gps_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic [7:0]       store_q [REPLY_BYTES];
	reply_t           reply_s1;
	logic             accept;
	logic             room;

	assign req.ready = !reply_s1.valid || advance;
	assign accept    = req.valid && req.ready;
	assign room      = pos_q < REPLY_CNT;
	assign pos_next  = room ? pos_q + POS_W'(1) : pos_q;
	assign reply     = reply_s1;

	for (genvar i = 0; i < REPLY_BYTES; i++) begin : g_view
		assign store[i] = store_q[i];
	end

	// Bytes past the end of the file are dropped; the count saturates.
	always_ff @(posedge clk) begin
		if (accept && room) begin
			store_q[pos_q[IDX_W-1:0]] <= req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			reply_s1 <= '0;
		end else begin
			if (accept) begin
				pos_q <= req.last_byte ? '0 : pos_next;
			end
			if (accept && req.last_byte) begin
				reply_s1.valid <= 1'b1;
				reply_s1.now   <= req.now_us;
				reply_s1.count <= pos_next;
			end else if (advance) begin
				reply_s1.valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/gps_decode.sv]
// Reply decode, pad state registers and the result register.
`default_nettype none
module gps_decode (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  gps_pkg::cfg_t                         regs,
	input  gps_pkg::reply_t                       reply,
	input  wire logic [gps_pkg::REPLY_BYTES-1:0][7:0] store,
	output logic                                  advance,
	gps_rsp_if.source                             rsp
);
	import gps_pkg::*;

	// Pad state.
	cmd_t              pending_q;
	logic [7:0]        mode_q;
	logic [31:0]       model_q;
	logic [15:0]       buttons_q;
	logic [7:0]        analog_q [ANALOG_BYTES];
	logic [TIME_W-1:0] change_q;

	// Result register.
	logic              out_valid_q;
	cmd_t              cmd_q;
	logic [TIME_W-1:0] due_q;
	logic [4:0]        len_q;
	logic              report_q;
	logic [7:0]        mode_out_q;
	logic [31:0]       model_out_q;
	logic [15:0]       buttons_out_q;
	logic [63:0]       lo_q;
	logic [63:0]       hi_q;

	logic [7:0]          rb [VIEW_N];
	logic [ANALOG_BYTES-1:0] diff;
	logic [127:0]        analog_flat;
	cmd_t                cmd_d;
	logic [DELAY_W-1:0]  dt;
	logic                report_d;
	logic                clear;
	logic                change;
	logic                use_analog;
	logic                store_analog;
	logic                active;
	logic                bad_header;
	logic                all_ff;
	logic [7:0]          mode_d;
	logic [31:0]         model_d;
	logic [15:0]         buttons_d;
	logic [TIME_W-1:0]   change_d;
	logic [4:0]          len_d;
	logic [TIME_W:0]     due_sum;
	logic [TIME_W:0]     deadline;
	logic                commit;

	// Decode view of the reply: positions past the file read as zero.
	for (genvar i = 0; i < VIEW_N; i++) begin : g_rb
		if (i < REPLY_BYTES) begin : g_in
			assign rb[i] = store[i];
		end else begin : g_out
			assign rb[i] = 8'h00;
		end
	end

	for (genvar i = 0; i < ANALOG_BYTES; i++) begin : g_diff
		assign diff[i] = rb[5 + i] != analog_q[i];
	end

	assign bad_header = rb[0] != HDR_BYTE || (rb[2] != HDR_Z && rb[2] != 8'h00);
	assign all_ff     = rb[0] == HDR_BYTE && rb[1] == HDR_BYTE && rb[2] == HDR_BYTE;
	assign use_analog = mode_q != MODE_DIGITAL && reply.count == REPLY_CNT;
	assign deadline   = {1'b0, change_q} + {{(TIME_W + 1 - WINDOW_W){1'b0}}, regs.idle_us};

	always_comb begin
		cmd_d        = CMD_READ;
		dt           = regs.query_us;
		report_d     = 1'b0;
		clear        = 1'b0;
		change       = 1'b0;
		store_analog = 1'b0;
		active       = 1'b0;
		mode_d       = mode_q;
		model_d      = model_q;
		buttons_d    = buttons_q;
		change_d     = change_q;
		case (pending_q)
			CMD_ENTER: begin
				if (all_ff) begin
					// No pad answered: retry discovery later.
					cmd_d = CMD_ENTER;
					dt    = regs.discovery_us;
				end else if (!bad_header) begin
					mode_d = rb[1];
					cmd_d  = CMD_QUERY;
				end
			end
			CMD_QUERY: begin
				model_d = {rb[6], rb[5], rb[4], rb[3]};
				cmd_d   = (rb[6] >= ALIGN_MIN) ? CMD_ALIGN : CMD_EXIT;
			end
			CMD_ALIGN: cmd_d = CMD_EXIT;
			CMD_EXIT:  cmd_d = CMD_READ;
			default: begin
				if (bad_header) begin
					// Disconnect: all pad state returns to its reset value.
					report_d  = mode_q != 8'h00;
					clear     = 1'b1;
					mode_d    = '0;
					model_d   = '0;
					buttons_d = '0;
					change_d  = '0;
					dt        = regs.discovery_us;
					cmd_d     = CMD_ENTER;
				end else if (mode_q != rb[1]) begin
					mode_d = rb[1];
					cmd_d  = CMD_ENTER;
				end else begin
					change = rb[3] != buttons_q[7:0] || rb[4] != buttons_q[15:8] ||
						(use_analog && (|diff));
					active = change || ({1'b0, reply.now} < deadline);
					if (change) begin
						buttons_d    = {rb[4], rb[3]};
						change_d     = reply.now;
						store_analog = use_analog;
						report_d     = 1'b1;
					end
					dt = active ? regs.active_us : regs.passive_us;
				end
			end
		endcase
	end

	always_comb begin
		case (cmd_d)
			CMD_ENTER: len_d = LEN_SHORT;
			CMD_READ:  len_d = (mode_d == MODE_DIGITAL) ? LEN_SHORT : LEN_FULL;
			default:   len_d = LEN_CFG;
		endcase
	end

	assign due_sum = {1'b0, reply.now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, dt};

	// Analog bytes as they stand after this reply, zero above the kept count.
	for (genvar i = 0; i < ANALOG_SLOTS; i++) begin : g_flat
		if (i < ANALOG_BYTES) begin : g_kept
			assign analog_flat[8*i +: 8] = clear ? 8'h00 :
				(store_analog ? rb[5 + i] : analog_q[i]);
		end else begin : g_zero
			assign analog_flat[8*i +: 8] = 8'h00;
		end
	end

	assign advance = !out_valid_q || rsp.ready;
	assign commit  = reply.valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= CMD_ENTER;
			mode_q      <= '0;
			model_q     <= '0;
			buttons_q   <= '0;
			change_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ANALOG_BYTES; i++) begin
				analog_q[i] <= '0;
			end
		end else begin
			if (commit) begin
				pending_q <= cmd_d;
				mode_q    <= mode_d;
				model_q   <= model_d;
				buttons_q <= buttons_d;
				change_q  <= change_d;
				for (int i = 0; i < ANALOG_BYTES; i++) begin
					analog_q[i] <= analog_flat[8*i +: 8];
				end
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			cmd_q         <= cmd_d;
			due_q         <= due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];
			len_q         <= len_d;
			report_q      <= report_d;
			mode_out_q    <= mode_d;
			model_out_q   <= model_d;
			buttons_out_q <= buttons_d;
			lo_q          <= analog_flat[63:0];
			hi_q          <= analog_flat[127:64];
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.next_command    = cmd_q;
	assign rsp.next_due_us     = due_q;
	assign rsp.reply_length    = len_q;
	assign rsp.report          = report_q;
	assign rsp.device_mode     = mode_out_q;
	assign rsp.model_type      = model_out_q[7:0];
	assign rsp.model_modes     = model_out_q[15:8];
	assign rsp.model_mode      = model_out_q[23:16];
	assign rsp.model_actuators = model_out_q[31:24];
	assign rsp.buttons         = buttons_out_q;
	assign rsp.analog_low      = lo_q;
	assign rsp.analog_high     = hi_q;

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the pad poll sequencer: random reply streams checked against a behavioral model.
module tb;
	import gps_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASES = 6;
	localparam int BYTES_PER_PHASE = 140;
	localparam int LONGEST_REPLY = 28;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam logic [7:0] HDR_ZERO = 8'h00;
	localparam logic [7:0] MODE_NONE = 8'h00;
	localparam logic [7:0] MODE_ANALOG = 8'h73;
	localparam logic [7:0] MODE_PRESSURE = 8'h79;
	localparam logic [7:0] MODE_CONFIG = 8'hF3;

	typedef struct {
		logic [7:0]        data;
		logic              last;
		logic [TIME_W-1:0] stamp;
	} pad_byte_t;

	typedef struct {
		cmd_t              command;
		logic [TIME_W-1:0] due;
		logic [4:0]        length;
		logic              report;
		logic [7:0]        mode;
		logic [31:0]       model;
		logic [15:0]       buttons;
		logic [63:0]       analog_lo;
		logic [63:0]       analog_hi;
	} poll_plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gps_req_if req ();
	gps_rsp_if rsp ();
	gps_cfg_if cfg ();

	gamepad_poll_sequencer dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	always #HALF_PERIOD clk = ~clk;

	// Behavioral copy of the sequencer: configuration and pad state.
	logic [DELAY_W-1:0]  m_discovery, m_query, m_active, m_passive;
	logic [WINDOW_W-1:0] m_idle;
	logic [7:0]          m_rumble_small, m_rumble_large;
	cmd_t                m_pending;
	int                  m_pos;
	logic [7:0]          m_reply [REPLY_BYTES];
	logic [7:0]          m_mode;
	logic [31:0]         m_model;
	logic [15:0]         m_buttons;
	logic [7:0]          m_analog [ANALOG_SLOTS];
	logic [TIME_W-1:0]   m_last_change;
	logic                m_differs;

	poll_plan_t expected_plans[$];
	pad_byte_t  pad_feed[$];

	int  mismatches = 0;
	int  results_checked = 0;
	int  bytes_queued = 0;
	int  feed_gap = 0;
	int  drain_gap = 0;
	logic req_fire = 1'b0;
	logic calm = 1'b0;

	// Stimulus generator state: what a well-behaved pad would currently answer.
	logic [7:0]        gen_mode;
	logic [15:0]       gen_buttons;
	logic [7:0]        gen_analog [ANALOG_SLOTS];
	logic [TIME_W-1:0] gen_clock;

	function automatic logic [TIME_W-1:0] rand48();
		return TIME_W'({$urandom(), $urandom()});
	endfunction

	task automatic plan_next_command(input pad_byte_t b);
		poll_plan_t        p;
		cmd_t              follow;
		int                count;
		logic [TIME_W:0]   sum;
		logic [DELAY_W-1:0] delay;
		logic [63:0]       horizon;
		logic              change, use_analog, bad_hdr, active;
		if (m_pos < REPLY_BYTES) begin
			m_reply[m_pos] = b.data;
			m_pos++;
		end
		if (!b.last)
			return;
		count = m_pos;
		m_pos = 0;
		p.report = 1'b0;
		bad_hdr = m_reply[0] != HDR_BYTE || (m_reply[2] != HDR_Z && m_reply[2] != HDR_ZERO);
		case (m_pending)
			CMD_ENTER: begin
				if (m_reply[0] == HDR_BYTE && m_reply[1] == HDR_BYTE && m_reply[2] == HDR_BYTE) begin
					delay = m_discovery;
					follow = CMD_ENTER;
				end else begin
					delay = m_query;
					if (bad_hdr) begin
						follow = CMD_READ;
					end else begin
						m_mode = m_reply[1];
						follow = CMD_QUERY;
					end
				end
			end
			CMD_QUERY: begin
				m_model = {m_reply[6], m_reply[5], m_reply[4], m_reply[3]};
				delay = m_query;
				follow = m_reply[6] >= ALIGN_MIN ? CMD_ALIGN : CMD_EXIT;
			end
			CMD_ALIGN: begin
				delay = m_query;
				follow = CMD_EXIT;
			end
			CMD_EXIT: begin
				delay = m_query;
				follow = CMD_READ;
			end
			default: begin
				if (bad_hdr) begin
					// A broken read reply means the pad went away.
					p.report = m_mode != MODE_NONE;
					m_mode = MODE_NONE;
					m_model = '0;
					m_buttons = '0;
					for (int i = 0; i < ANALOG_SLOTS; i++)
						m_analog[i] = '0;
					m_last_change = '0;
					m_differs = 1'b0;
					delay = m_discovery;
					follow = CMD_ENTER;
				end else if (m_mode != m_reply[1]) begin
					m_mode = m_reply[1];
					delay = m_query;
					follow = CMD_ENTER;
				end else begin
					use_analog = m_mode != MODE_DIGITAL && count == REPLY_BYTES;
					change = {m_reply[4], m_reply[3]} != m_buttons;
					if (use_analog)
						for (int i = 0; i < ANALOG_BYTES; i++)
							if (m_reply[5 + i] != m_analog[i])
								change = 1'b1;
					horizon = 64'(m_last_change) + 64'(m_idle);
					active = change || 64'(b.stamp) < horizon;
					m_differs = change;
					if (change) begin
						m_buttons = {m_reply[4], m_reply[3]};
						if (use_analog)
							for (int i = 0; i < ANALOG_BYTES; i++)
								m_analog[i] = m_reply[5 + i];
						m_last_change = b.stamp;
						p.report = 1'b1;
					end
					delay = active ? m_active : m_passive;
					follow = CMD_READ;
				end
			end
		endcase
		m_pending = follow;
		sum = {1'b0, b.stamp} + (TIME_W + 1)'(delay);
		p.command = follow;
		p.due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		if (follow == CMD_ENTER)
			p.length = LEN_SHORT;
		else if (follow == CMD_READ)
			p.length = m_mode == MODE_DIGITAL ? LEN_SHORT : LEN_FULL;
		else
			p.length = LEN_CFG;
		p.mode = m_mode;
		p.model = m_model;
		p.buttons = m_buttons;
		for (int i = 0; i < 8; i++) begin
			p.analog_lo[8*i +: 8] = m_analog[i];
			p.analog_hi[8*i +: 8] = m_analog[i + 8];
		end
		expected_plans.push_back(p);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		poll_plan_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_plans.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result arrived with none outstanding", $time);
			end else begin
				want = expected_plans.pop_front();
				check_field("next_command", want.command, rsp.next_command);
				check_field("next_due_us", want.due, rsp.next_due_us);
				check_field("reply_length", want.length, rsp.reply_length);
				check_field("report", want.report, rsp.report);
				check_field("device_mode", want.mode, rsp.device_mode);
				check_field("model_type", want.model[7:0], rsp.model_type);
				check_field("model_modes", want.model[15:8], rsp.model_modes);
				check_field("model_mode", want.model[23:16], rsp.model_mode);
				check_field("model_actuators", want.model[31:24], rsp.model_actuators);
				check_field("buttons", want.buttons, rsp.buttons);
				check_field("analog_low", want.analog_lo, rsp.analog_low);
				check_field("analog_high", want.analog_hi, rsp.analog_high);
				results_checked++;
			end
		end
		req_fire = arst_n && req.valid && req.ready;
		if (req_fire)
			plan_next_command('{req.rx_byte, req.last_byte, req.now_us});
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DISCOVERY:    m_discovery = cfg.data[DELAY_W-1:0];
				REG_QUERY:        m_query = cfg.data[DELAY_W-1:0];
				REG_ACTIVE:       m_active = cfg.data[DELAY_W-1:0];
				REG_PASSIVE:      m_passive = cfg.data[DELAY_W-1:0];
				REG_IDLE:         m_idle = cfg.data[WINDOW_W-1:0];
				REG_RUMBLE_SMALL: m_rumble_small = cfg.data[7:0];
				REG_RUMBLE_LARGE: m_rumble_large = cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin : feed_driver
		pad_byte_t b;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_fire) begin
			if (feed_gap > 0) begin
				feed_gap--;
				req.valid <= 1'b0;
			end else if (pad_feed.size() != 0) begin
				b = pad_feed.pop_front();
				req.valid <= 1'b1;
				req.rx_byte <= b.data;
				req.last_byte <= b.last;
				req.now_us <= b.stamp;
				if (!calm && $urandom_range(0, 7) == 0)
					feed_gap = $urandom_range(1, 12);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : result_sink
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (drain_gap > 0) begin
			drain_gap--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
			if (!calm && $urandom_range(0, 7) == 0)
				drain_gap = $urandom_range(1, 12);
		end
	end

	task automatic queue_reply(input logic [7:0] data [32], input int n,
			input logic [TIME_W-1:0] stamp);
		for (int i = 0; i < n; i++)
			pad_feed.push_back('{data[i], logic'(i == n - 1), i == n - 1 ? stamp : rand48()});
		bytes_queued += n;
	endtask

	task automatic add_exchange();
		logic [7:0] data [32];
		int kind, n, pick;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 15))
			0: gen_clock = rand48();
			1: gen_clock = TIME_MAX - TIME_W'($urandom_range(0, 1000000));
			2: gen_clock += TIME_W'($urandom());
			default: gen_clock += TIME_W'($urandom_range(0, 400000));
		endcase
		for (int i = 0; i < 32; i++)
			data[i] = 8'($urandom());
		if (kind >= 86 && kind <= 90) begin
			// Nobody on the line: every byte reads high.
			for (int i = 0; i < 32; i++)
				data[i] = HDR_BYTE;
			n = $urandom_range(3, 9);
		end else if (kind >= 91 && kind <= 95) begin
			if ($urandom_range(0, 1) == 1)
				data[0] = HDR_BYTE;
			n = $urandom_range(3, REPLY_BYTES);
		end else begin
			if (kind >= 78 && kind <= 85) begin
				case ($urandom_range(0, 4))
					0: gen_mode = MODE_DIGITAL;
					1: gen_mode = MODE_ANALOG;
					2: gen_mode = MODE_PRESSURE;
					3: gen_mode = MODE_NONE;
					default: gen_mode = 8'($urandom());
				endcase
			end
			if ($urandom_range(0, 3) == 0)
				gen_buttons = 16'($urandom());
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1) == 1) begin
					gen_analog[$urandom_range(0, ANALOG_SLOTS - 1)] = 8'($urandom());
				end else begin
					for (int i = 0; i < ANALOG_SLOTS; i++)
						gen_analog[i] = 8'($urandom());
					// Byte six doubles as the actuator count of a query reply.
					if ($urandom_range(0, 1) == 1)
						gen_analog[1] = 8'($urandom_range(0, 3));
				end
			end
			data[0] = HDR_BYTE;
			data[1] = gen_mode;
			data[2] = $urandom_range(0, 9) == 0 ? HDR_ZERO : HDR_Z;
			data[3] = gen_buttons[7:0];
			data[4] = gen_buttons[15:8];
			for (int i = 0; i < ANALOG_SLOTS; i++)
				data[5 + i] = gen_analog[i];
			pick = $urandom_range(0, 19);
			if (kind >= 96)
				n = pick < 10 ? $urandom_range(REPLY_BYTES + 1, LONGEST_REPLY) : $urandom_range(1, 4);
			else if (pick < 15)
				n = gen_mode == MODE_DIGITAL ? int'(LEN_SHORT) : REPLY_BYTES;
			else if (pick < 18)
				n = LEN_CFG;
			else
				n = gen_mode == MODE_DIGITAL ? REPLY_BYTES : int'(LEN_SHORT);
		end
		queue_reply(data, n, gen_clock);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic program_settings(input logic [31:0] discovery, query, active, passive,
			idle, rumble_s, rumble_l);
		write_reg(REG_DISCOVERY, discovery);
		write_reg(REG_QUERY, query);
		write_reg(REG_ACTIVE, active);
		write_reg(REG_PASSIVE, passive);
		write_reg(REG_IDLE, idle);
		write_reg(REG_RUMBLE_SMALL, rumble_s);
		write_reg(REG_RUMBLE_LARGE, rumble_l);
	endtask

	task automatic wait_idle();
		while (pad_feed.size() != 0 || req.valid || expected_plans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] data [32];
		int budget;
		req.valid = 1'b0;
		req.rx_byte = '0;
		req.last_byte = 1'b0;
		req.now_us = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_DISCOVERY;
		cfg.data = '0;
		m_discovery = DISCOVERY_RST;
		m_query = QUERY_RST;
		m_active = ACTIVE_RST;
		m_passive = PASSIVE_RST;
		m_idle = IDLE_RST;
		m_rumble_small = '0;
		m_rumble_large = '0;
		m_pending = CMD_ENTER;
		m_pos = 0;
		for (int i = 0; i < REPLY_BYTES; i++)
			m_reply[i] = '0;
		m_mode = MODE_NONE;
		m_model = '0;
		m_buttons = '0;
		for (int i = 0; i < ANALOG_SLOTS; i++) begin
			m_analog[i] = '0;
			gen_analog[i] = 8'($urandom());
		end
		m_last_change = '0;
		m_differs = 1'b0;
		gen_mode = MODE_DIGITAL;
		gen_buttons = '0;
		gen_clock = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// The first reply is long enough that every byte a decode looks at has been written.
		data = '{default: HDR_BYTE};
		queue_reply(data, 7, '0);
		data[1] = MODE_DIGITAL;
		data[2] = HDR_Z;
		data[3] = 8'h00;
		data[4] = 8'h00;
		queue_reply(data, LEN_SHORT, TIME_MAX - 10);
		data[1] = MODE_CONFIG;
		data[3] = MODE_ANALOG;
		data[4] = 8'h07;
		data[5] = 8'h01;
		data[6] = ALIGN_MIN;
		data[7] = 8'h00;
		data[8] = 8'h00;
		queue_reply(data, LEN_CFG, TIME_MAX);
		queue_reply(data, 3, '0);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1: begin
						program_settings($urandom(), $urandom(), $urandom(), $urandom(),
							$urandom(), $urandom(), $urandom());
						write_reg(REG_NONE, $urandom());
					end
					2: program_settings('1, '1, '1, '1, '1, '1, '1);
					3: program_settings('0, '0, '0, '0, '0, '0, '0);
					4: program_settings($urandom_range(0, 1000), $urandom_range(0, 1000), 1,
						$urandom_range(0, 200000), $urandom_range(0, 300000),
						$urandom_range(0, 255), $urandom_range(0, 255));
					default: program_settings(DISCOVERY_RST, QUERY_RST, ACTIVE_RST, PASSIVE_RST,
						IDLE_RST, '0, '0);
				endcase
			end
			calm = phase == PHASES - 1;
			budget = bytes_queued + BYTES_PER_PHASE;
			while (bytes_queued < budget)
				add_exchange();
		end
		wait_idle();
		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d reply bytes over %0d register settings; %0d results checked.",
			bytes_queued, PHASES, results_checked);
		if (mismatches == 0)
			$display("gamepad_poll_sequencer: match");
		else
			$display("gamepad_poll_sequencer: mismatch");
		$finish;
	end

	initial begin : watchdog
		#(2 * HALF_PERIOD * TIMEOUT_CYCLES);
		$display("Timed out with %0d results outstanding.", expected_plans.size());
		$display("gamepad_poll_sequencer: mismatch");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gps_pkg.sv
hw/rtl/gps_ifs.sv
hw/rtl/gps_regs.sv
hw/rtl/gps_capture.sv
hw/rtl/gps_decode.sv
hw/rtl/gamepad_poll_sequencer.sv
sim/tb.sv
